// ----- src/nsc_pkg.sv -----
// ----------------------------------------------------------------------------
// nsc_pkg
// Shared types, character codes and helper functions for the NMEA sentence
// checksum framer.
// ----------------------------------------------------------------------------
package nsc_pkg;

    localparam logic [7:0]  CH_DOLLAR      = 8'h24;
    localparam logic [7:0]  CH_COMMA       = 8'h2C;
    localparam logic [7:0]  CH_STAR        = 8'h2A;

    localparam logic [7:0]  SENTENCE_BYTES = 8'd128;
    localparam logic [7:0]  HEADER_LEN     = 8'd6;

    localparam logic [47:0] HEADER_RESET   = 48'h244750524D43;

    typedef enum logic [1:0] {
        MODE_HUNT,
        MODE_HEADER,
        MODE_DATA,
        MODE_CHECK
    } nsc_mode_t;

    typedef struct packed {
        logic       checksum_ok;
        logic [7:0] computed_checksum;
        logic [7:0] received_checksum;
        logic [7:0] sentence_length;
    } nsc_result_t;

    // Header character at position idx, first character in the top byte.
    function automatic logic [7:0] hdr_char(input logic [47:0] hdr, input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = hdr[47:40];
            3'd1:    c = hdr[39:32];
            3'd2:    c = hdr[31:24];
            3'd3:    c = hdr[23:16];
            3'd4:    c = hdr[15:8];
            3'd5:    c = hdr[7:0];
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Non-hex characters decode as zero.
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c inside {[8'h30:8'h39]})
        begin
            v = c - 8'h30;
        end
        else if (c inside {[8'h41:8'h46]})
        begin
            v = c - 8'h37;
        end
        else if (c inside {[8'h61:8'h66]})
        begin
            v = c - 8'h57;
        end
        return v[3:0];
    endfunction

endpackage

// ----- src/nsc_if.sv -----
// ----------------------------------------------------------------------------
// NMEA framer channels
// Valid/ready channels for received bytes, results and the header register.
// ----------------------------------------------------------------------------
interface nsc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nsc_result_if;
    logic       valid;
    logic       ready;
    logic       checksum_ok;
    logic [7:0] computed_checksum;
    logic [7:0] received_checksum;
    logic [7:0] sentence_length;

    modport source (output valid, output checksum_ok, output computed_checksum,
                    output received_checksum, output sentence_length, input ready);
    modport sink   (input valid, input checksum_ok, input computed_checksum,
                    input received_checksum, input sentence_length, output ready);
endinterface

interface nsc_cfg_if;
    logic        valid;
    logic        ready;
    logic [47:0] header_text;

    modport source (output valid, output header_text, input ready);
    modport sink   (input valid, input header_text, output ready);
endinterface

// ----- src/nsc_in_stage.sv -----
// ----------------------------------------------------------------------------
// nsc_in_stage
// Input register: captures one received byte and holds it until the parser
// consumes it.
// ----------------------------------------------------------------------------
module nsc_in_stage
    import nsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    nsc_byte_if.sink   rx,
    input  logic       advance,
    output logic       byte_valid,
    output logic [7:0] byte_data
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       take;

    assign rx.ready   = !valid_reg || advance;
    assign take       = rx.valid && rx.ready;
    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= rx.rx_byte;
        end
    end

endmodule

// ----- src/nsc_parser.sv -----
// ----------------------------------------------------------------------------
// nsc_parser
// Sentence state machine: header compare, running XOR, checksum decode and
// length count. One byte per step.
// ----------------------------------------------------------------------------
module nsc_parser
    import nsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  b,
    input  logic [47:0] header_text,
    output logic        res_valid,
    output nsc_result_t res
);

    nsc_mode_t  mode_reg,     mode_next;
    logic [7:0] count_reg,    count_next;
    logic       match_reg,    match_next;
    logic [7:0] xor_reg,      xor_next;
    logic       xor_stop_reg, xor_stop_next;
    logic [3:0] hi_nib_reg,   hi_nib_next;
    logic       nib_idx_reg,  nib_idx_next;

    logic       hdr_bad;
    logic       match_upd;
    logic [7:0] count_inc;
    logic [3:0] lo_nib;
    logic [7:0] rx_sum;

    assign count_inc = count_reg + 8'd1;
    assign hdr_bad   = (count_reg < HEADER_LEN) && (b != hdr_char(header_text, count_reg[2:0]));
    assign match_upd = match_reg && !hdr_bad;
    assign lo_nib    = hex_value(b);
    assign rx_sum    = {hi_nib_reg, lo_nib};

    // next mode
    always_comb
    begin
        mode_next = mode_reg;
        if (step)
        begin
            case (mode_reg)
                MODE_HUNT:
                begin
                    if (b == CH_DOLLAR)
                    begin
                        mode_next = MODE_HEADER;
                    end
                end
                MODE_HEADER:
                begin
                    if (b == CH_COMMA)
                    begin
                        mode_next = (match_upd && (count_inc >= HEADER_LEN)) ?
                                    MODE_DATA : MODE_HUNT;
                    end
                end
                MODE_DATA:
                begin
                    if (b == CH_STAR)
                    begin
                        mode_next = MODE_CHECK;
                    end
                end
                MODE_CHECK:
                begin
                    if (nib_idx_reg)
                    begin
                        mode_next = MODE_HUNT;
                    end
                end
                default:
                begin
                    mode_next = MODE_HUNT;
                end
            endcase
            // overlong sentence aborts
            if (count_next >= SENTENCE_BYTES)
            begin
                mode_next = MODE_HUNT;
            end
        end
    end

    // datapath and result
    always_comb
    begin
        count_next    = count_reg;
        match_next    = match_reg;
        xor_next      = xor_reg;
        xor_stop_next = xor_stop_reg;
        hi_nib_next   = hi_nib_reg;
        nib_idx_next  = nib_idx_reg;
        res_valid     = 1'b0;
        res.checksum_ok       = (rx_sum == xor_reg);
        res.computed_checksum = xor_reg;
        res.received_checksum = rx_sum;
        res.sentence_length   = count_inc;
        if (step)
        begin
            case (mode_reg)
                MODE_HUNT:
                begin
                    if (b == CH_DOLLAR)
                    begin
                        count_next    = 8'd1;
                        xor_next      = 8'h00;
                        xor_stop_next = 1'b0;
                        match_next    = (hdr_char(header_text, 3'd0) == CH_DOLLAR);
                    end
                end
                MODE_HEADER, MODE_DATA:
                begin
                    if (mode_reg == MODE_HEADER)
                    begin
                        match_next = match_upd;
                    end
                    if (!xor_stop_reg)
                    begin
                        if (b == CH_STAR)
                        begin
                            xor_stop_next = 1'b1;
                        end
                        else
                        begin
                            xor_next = xor_reg ^ b;
                        end
                    end
                    count_next = count_inc;
                    if ((mode_reg == MODE_DATA) && (b == CH_STAR))
                    begin
                        nib_idx_next = 1'b0;
                    end
                end
                MODE_CHECK:
                begin
                    count_next = count_inc;
                    if (!nib_idx_reg)
                    begin
                        hi_nib_next  = lo_nib;
                        nib_idx_next = 1'b1;
                    end
                    else
                    begin
                        res_valid    = 1'b1;
                        nib_idx_next = 1'b0;
                    end
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_HUNT;
            count_reg    <= 8'd0;
            match_reg    <= 1'b1;
            xor_reg      <= 8'h00;
            xor_stop_reg <= 1'b0;
            hi_nib_reg   <= 4'h0;
            nib_idx_reg  <= 1'b0;
        end
        else
        begin
            mode_reg     <= mode_next;
            count_reg    <= count_next;
            match_reg    <= match_next;
            xor_reg      <= xor_next;
            xor_stop_reg <= xor_stop_next;
            hi_nib_reg   <= hi_nib_next;
            nib_idx_reg  <= nib_idx_next;
        end
    end

endmodule

// ----- src/nsc_out_stage.sv -----
// ----------------------------------------------------------------------------
// nsc_out_stage
// Result register: holds one finished result until the sink takes it.
// ----------------------------------------------------------------------------
module nsc_out_stage
    import nsc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  nsc_result_t  res,
    output logic         advance,
    nsc_result_if.source result
);

    logic        valid_reg;
    logic        valid_next;
    nsc_result_t data_reg;

    // pipeline may move when the slot is empty or being drained
    assign advance = !valid_reg || result.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && load)
        begin
            data_reg <= res;
        end
    end

    assign result.valid             = valid_reg;
    assign result.checksum_ok       = data_reg.checksum_ok;
    assign result.computed_checksum = data_reg.computed_checksum;
    assign result.received_checksum = data_reg.received_checksum;
    assign result.sentence_length   = data_reg.sentence_length;

endmodule

// ----- src/nmea_sentence_checksum_framer.sv -----
// ----------------------------------------------------------------------------
// nmea_sentence_checksum_framer
// Frames NMEA sentences from a byte stream, checks the header and the XOR
// checksum, and reports one result per complete sentence.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                   | per word
//  ---------+-----+-------------------------------------------+-----------------
//  rx       | in  | rx_byte[7:0]                              | one character
//  result   | out | checksum_ok, computed/received_checksum,  | one sentence
//           |     | sentence_length                           |
//  cfg      | in  | header_text[47:0]                         | header register
//
//  One byte per cycle while results are taken; a byte is held in the input
//  register, then the parser state and the result register load on the same
//  edge, so a result is valid once its last checksum character has passed the
//  input register. Reset puts the parser in hunt mode and loads header_text
//  with "$GPRMC". A held result stalls the parser; rx keeps one byte buffered
//  meanwhile. cfg is always ready; the user must write it only while no
//  sentence is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module nmea_sentence_checksum_framer
    import nsc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    nsc_byte_if.sink     rx,
    nsc_result_if.source result,
    nsc_cfg_if.sink      cfg
);

    logic [47:0] header_reg;
    logic        advance;
    logic        byte_valid;
    logic [7:0]  byte_data;
    logic        step;
    logic        res_valid;
    nsc_result_t res;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= HEADER_RESET;
        end
        else if (cfg.valid)
        begin
            header_reg <= cfg.header_text;
        end
    end

    assign step = byte_valid && advance;

    nsc_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .advance    (advance),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    nsc_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .b           (byte_data),
        .header_text (header_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    nsc_out_stage u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (res_valid),
        .res     (res),
        .advance (advance),
        .result  (result)
    );

endmodule

// ----- sim/nmea_sentence_checksum_framer_tb.sv -----
// ----------------------------------------------------------------------------
// nmea_sentence_checksum_framer_tb
// Self-checking bench for the NMEA sentence framer: a short table of hand
// written sentences, then random sentences (good, damaged, over length and
// line noise) under several header settings, with random gaps on both sides.
// Every result word is checked against a cycle-free model of the parser, or for table rows against the table.
// ----------------------------------------------------------------------------
module nmea_sentence_checksum_framer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nsc_pkg::*;

    localparam int MAX_GAP       = 12;
    localparam int SETTLE_CYCLES = 8;
    localparam int ITEM_TARGET   = 2000;
    localparam int DIR_ROWS      = 13;

    localparam logic [7:0] CH_ZERO    = "0";
    localparam logic [7:0] CH_NINE    = "9";
    localparam logic [7:0] CH_UPPER_A = "A";
    localparam logic [7:0] CH_UPPER_F = "F";
    localparam logic [7:0] CH_UPPER_Z = "Z";
    localparam logic [7:0] CH_LOWER_A = "a";
    localparam logic [7:0] CH_LOWER_F = "f";
    localparam logic [7:0] CH_TILDE   = "~";
    localparam logic [7:0] CH_BANG    = "!";
    localparam logic [7:0] BYTE_NUL   = 8'h00;

    localparam logic [47:0] HDR_GGA    = 48'h244750474741;   // $GPGGA
    localparam logic [47:0] HDR_STAR   = 48'h24472A524D43;   // $G*RMC
    localparam logic [47:0] HDR_COMMA5 = 48'h244750524D2C;   // $GPRM,
    localparam logic [47:0] HDR_ZERO   = 48'h000000000000;
    localparam logic [47:0] HDR_ONES   = 48'hFFFFFFFFFFFF;

    typedef enum
    {
        SHAPE_GOOD,
        SHAPE_SHORT,
        SHAPE_LONG,
        SHAPE_BROKEN,
        SHAPE_NOISE
    } sentence_shape_t;

    typedef struct packed {
        bit          load;
        logic [47:0] hdr;
        bit          pinned;
        nsc_result_t want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;

    nsc_byte_if   rx_ch();
    nsc_result_if res_ch();
    nsc_cfg_if    cfg_ch();

    nmea_sentence_checksum_framer dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // '~' in the table text stands for a NUL byte
    string dir_text [DIR_ROWS] = '{
        "\377~\377~",
        "$GPRMC,*67",
        "$GPRMC,~\377*98",
        "$GPRMC,*ZZ",
        "$GPRMC,*6f",
        "$GPRMC,$*43",
        "$GPR,A*00",
        "$GPXMC,*00",
        "$GPRMCA,b*00",
        "$G*RMC,A*47",
        "$GPRM,*24",
        "$GPRMC,*67",
        "$\377\377\377\377\377,*00"
    };

    dir_row_t dir_ctl [DIR_ROWS] = '{
        '{1'b0, HDR_ZERO,   1'b0, '{1'b0, 8'h00, 8'h00, 8'd0}},
        '{1'b0, HDR_ZERO,   1'b1, '{1'b1, 8'h67, 8'h67, 8'd10}},
        '{1'b0, HDR_ZERO,   1'b1, '{1'b1, 8'h98, 8'h98, 8'd12}},
        '{1'b0, HDR_ZERO,   1'b1, '{1'b0, 8'h67, 8'h00, 8'd10}},
        '{1'b0, HDR_ZERO,   1'b1, '{1'b0, 8'h67, 8'h6F, 8'd10}},
        '{1'b0, HDR_ZERO,   1'b1, '{1'b1, 8'h43, 8'h43, 8'd11}},
        '{1'b0, HDR_ZERO,   1'b0, '{1'b0, 8'h00, 8'h00, 8'd0}},
        '{1'b0, HDR_ZERO,   1'b0, '{1'b0, 8'h00, 8'h00, 8'd0}},
        '{1'b0, HDR_ZERO,   1'b0, '{1'b0, 8'h00, 8'h00, 8'd0}},
        '{1'b1, HDR_STAR,   1'b1, '{1'b1, 8'h47, 8'h47, 8'd11}},
        '{1'b1, HDR_COMMA5, 1'b1, '{1'b1, 8'h24, 8'h24, 8'd9}},
        '{1'b1, HDR_ZERO,   1'b0, '{1'b0, 8'h00, 8'h00, 8'd0}},
        '{1'b1, HDR_ONES,   1'b0, '{1'b0, 8'h00, 8'h00, 8'd0}}
    };

    // parser model state
    logic [47:0] fr_header;
    nsc_mode_t   fr_mode;
    logic [7:0]  fr_count;
    bit          fr_hdr_ok;
    logic [7:0]  fr_xor;
    bit          fr_xor_done;
    logic [3:0]  fr_hi;
    bit          fr_second;

    nsc_result_t reports_due [$];
    int          fault_count  = 0;
    int          bytes_framed = 0;
    bit          src_idle     = 1'b1;
    bit          sink_idle    = 1'b1;
    int          sink_hold    = 0;

    task automatic flag_mismatch(input string what, input int got, input int want);
        fault_count++;
        $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    endtask

    function automatic logic [7:0] hdr_at(input int unsigned idx);
        if (idx >= 6)
            return 8'h00;
        return fr_header[8 * (5 - idx) +: 8];
    endfunction

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE)
            return 4'(c - CH_ZERO);
        if (c >= CH_UPPER_A && c <= CH_UPPER_F)
            return 4'(c - CH_UPPER_A + 8'd10);
        if (c >= CH_LOWER_A && c <= CH_LOWER_F)
            return 4'(c - CH_LOWER_A + 8'd10);
        return 4'h0;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit lower);
        if (v < 4'd10)
            return CH_ZERO + 8'(v);
        return (lower ? CH_LOWER_A : CH_UPPER_A) + 8'(v) - 8'd10;
    endfunction

    // Advances the parser model by one byte; returns 1 when a sentence completes.
    function automatic bit frame_byte(input logic [7:0] b, output nsc_result_t r);
        logic [7:0] rx_sum;
        bit         done;
        done = 1'b0;
        r    = '0;
        case (fr_mode)
            MODE_HUNT:
            begin
                if (b == CH_DOLLAR)
                begin
                    fr_count    = 8'd1;
                    fr_xor      = 8'h00;
                    fr_xor_done = 1'b0;
                    fr_hdr_ok   = (hdr_at(0) == CH_DOLLAR);
                    fr_mode     = MODE_HEADER;
                end
            end
            MODE_HEADER, MODE_DATA:
            begin
                if (fr_mode == MODE_HEADER && fr_count < HEADER_LEN && b != hdr_at(fr_count))
                    fr_hdr_ok = 1'b0;
                if (!fr_xor_done)
                begin
                    if (b == CH_STAR)
                        fr_xor_done = 1'b1;
                    else
                        fr_xor = fr_xor ^ b;
                end
                fr_count = fr_count + 8'd1;
                if (fr_mode == MODE_HEADER)
                begin
                    if (b == CH_COMMA)
                        fr_mode = (fr_hdr_ok && fr_count >= HEADER_LEN) ? MODE_DATA : MODE_HUNT;
                end
                else if (b == CH_STAR)
                begin
                    fr_second = 1'b0;
                    fr_mode   = MODE_CHECK;
                end
            end
            default:
            begin
                fr_count = fr_count + 8'd1;
                if (!fr_second)
                begin
                    fr_hi     = nibble_of(b);
                    fr_second = 1'b1;
                end
                else
                begin
                    rx_sum              = {fr_hi, nibble_of(b)};
                    r.checksum_ok       = (rx_sum == fr_xor);
                    r.computed_checksum = fr_xor;
                    r.received_checksum = rx_sum;
                    r.sentence_length   = fr_count;
                    done                = 1'b1;
                    fr_second           = 1'b0;
                    fr_mode             = MODE_HUNT;
                end
            end
        endcase
        // over-length sentence drops back to hunting, after any result on this byte
        if (fr_count >= SENTENCE_BYTES)
            fr_mode = MODE_HUNT;
        return done;
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit pinned, input nsc_result_t pin_val);
        int          gap;
        bit          done;
        nsc_result_t r;
        gap = src_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge clk);
        while (!rx_ch.ready)
            @(posedge clk);
        done = frame_byte(b, r);
        if (done || pinned)
            reports_due.push_back(pinned ? pin_val : r);
    endtask

    // Closes any open sentence, drains all results, then writes the header.
    task automatic settle_and_load(input logic [47:0] hdr);
        nsc_result_t none;
        none = '0;
        while (fr_mode != MODE_HUNT)
        begin
            case (fr_mode)
                MODE_HEADER: send_byte(CH_COMMA, 1'b0, none);
                MODE_DATA:   send_byte(CH_STAR, 1'b0, none);
                default:     send_byte(CH_ZERO, 1'b0, none);
            endcase
        end
        rx_ch.valid <= 1'b0;
        while (reports_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.header_text <= hdr;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        fr_header = hdr;
    endtask

    task automatic send_sentence(input sentence_shape_t shape);
        logic [7:0]  line [$];
        logic [7:0]  sum;
        logic [7:0]  sent_sum;
        logic [7:0]  c;
        bit          stopped;
        bit          lower;
        int          n;
        int          k;
        nsc_result_t none;
        none = '0;
        if (shape == SHAPE_NOISE)
        begin
            n = $urandom_range(1, 8);
            repeat (n) send_byte(8'($urandom_range(0, 255)), 1'b0, none);
            return;
        end
        line.push_back(CH_DOLLAR);
        for (k = 1; k < HEADER_LEN; k++)
            line.push_back(hdr_at(k));
        // header longer than the compared part
        if (shape != SHAPE_SHORT && $urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 2)) line.push_back(8'($urandom_range(CH_UPPER_A, CH_UPPER_Z)));
        line.push_back(CH_COMMA);
        case (shape)
            SHAPE_SHORT: n = $urandom_range(0, 2);
            SHAPE_LONG:  n = $urandom_range(110, 130);
            default:     n = $urandom_range(0, 24);
        endcase
        for (k = 0; k < n; k++)
        begin
            c = 8'($urandom_range(0, 255));
            if (c == CH_STAR)
                c = CH_DOLLAR;
            line.push_back(c);
        end
        sum     = 8'h00;
        stopped = 1'b0;
        for (k = 1; k < line.size(); k++)
        begin
            if (!stopped)
            begin
                if (line[k] == CH_STAR)
                    stopped = 1'b1;
                else
                    sum = sum ^ line[k];
            end
        end
        line.push_back(CH_STAR);
        sent_sum = sum;
        if (shape != SHAPE_SHORT && $urandom_range(0, 5) == 0)
            sent_sum = 8'($urandom_range(0, 255));
        lower = $urandom_range(0, 1);
        line.push_back(hex_char(sent_sum[7:4], lower));
        line.push_back(hex_char(sent_sum[3:0], lower));
        if (shape != SHAPE_SHORT && $urandom_range(0, 15) == 0)
            line[line.size() - 1 - $urandom_range(0, 1)] = 8'($urandom_range(0, 255));
        if (shape == SHAPE_BROKEN)
        begin
            k = $urandom_range(1, line.size() - 1);
            if ($urandom_range(0, 1) == 0)
                line[k] = 8'($urandom_range(0, 255));
            else
                while (line.size() > k)
                    void'(line.pop_back());
        end
        foreach (line[i])
            send_byte(line[i], 1'b0, none);
        bytes_framed += line.size();
    endtask

    always @(posedge clk)
    begin : result_check
        nsc_result_t seen;
        nsc_result_t due;
        if (rst_n === 1'b1 && res_ch.valid && res_ch.ready)
        begin
            seen = {res_ch.checksum_ok, res_ch.computed_checksum,
                    res_ch.received_checksum, res_ch.sentence_length};
            if (reports_due.size() == 0)
                flag_mismatch("result word with none due", seen, 0);
            else
            begin
                due = reports_due.pop_front();
                if (seen.checksum_ok !== due.checksum_ok)
                    flag_mismatch("checksum_ok", seen.checksum_ok, due.checksum_ok);
                if (seen.computed_checksum !== due.computed_checksum)
                    flag_mismatch("computed_checksum", seen.computed_checksum,
                                  due.computed_checksum);
                if (seen.received_checksum !== due.received_checksum)
                    flag_mismatch("received_checksum", seen.received_checksum,
                                  due.received_checksum);
                if (seen.sentence_length !== due.sentence_length)
                    flag_mismatch("sentence_length", seen.sentence_length,
                                  due.sentence_length);
            end
        end
    end

    // result side: random stalls, plus long hold-offs on request
    initial
    begin : result_sink
        int gap;
        int hold;
        res_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (sink_hold > 0)
            begin
                hold      = sink_hold;
                sink_hold = 0;
                res_ch.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            else
            begin
                gap = sink_idle ? $urandom_range(0, MAX_GAP) : 0;
                if (gap > 0)
                begin
                    res_ch.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            res_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_ch.valid && sink_hold == 0);
        end
    end

    initial
    begin : stimulus
        logic [7:0]  c;
        logic [47:0] hdr;
        int          ph;
        int          phase_end;
        int          pick;
        int          guard;
        rst_n              <= 1'b0;
        rx_ch.valid        <= 1'b0;
        rx_ch.rx_byte      <= BYTE_NUL;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.header_text <= HDR_ZERO;

        fr_header   = HEADER_RESET;
        fr_mode     = MODE_HUNT;
        fr_count    = 8'd0;
        fr_hdr_ok   = 1'b1;
        fr_xor      = 8'h00;
        fr_xor_done = 1'b0;
        fr_hi       = 4'h0;
        fr_second   = 1'b0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (dir_ctl[i].load)
                settle_and_load(dir_ctl[i].hdr);
            for (int k = 0; k < dir_text[i].len(); k++)
            begin
                c = dir_text[i][k];
                if (c == CH_TILDE)
                    c = BYTE_NUL;
                send_byte(c, dir_ctl[i].pinned && k == dir_text[i].len() - 1,
                          dir_ctl[i].want);
            end
        end

        ph = 0;
        while (bytes_framed < ITEM_TARGET)
        begin
            case (ph % 5)
                0: hdr = HEADER_RESET;
                1: hdr = HDR_GGA;
                2:
                begin
                    hdr[47:40] = CH_DOLLAR;
                    for (int k = 0; k < 5; k++)
                        hdr[8 * k +: 8] = 8'($urandom_range(CH_BANG, CH_TILDE));
                end
                3: hdr = {16'($urandom), 32'($urandom)};
                default: hdr = HDR_COMMA5;
            endcase
            settle_and_load(hdr);

            // first phase: stall the result side while short sentences keep coming
            if (ph == 0)
            begin
                src_idle  = 1'b0;
                sink_hold = 250;
                repeat (8) send_sentence(SHAPE_SHORT);
            end

            src_idle  = ($urandom_range(0, 2) != 0);
            sink_idle = ($urandom_range(0, 2) != 0);
            phase_end = bytes_framed + ((ph % 5 == 3) ? 40 : 300);
            while (bytes_framed < phase_end)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 72)
                    send_sentence(SHAPE_GOOD);
                else if (pick < 80)
                    send_sentence(SHAPE_LONG);
                else if (pick < 92)
                    send_sentence(SHAPE_BROKEN);
                else
                    send_sentence(SHAPE_NOISE);
            end
            ph++;
        end

        rx_ch.valid <= 1'b0;
        guard = 0;
        while (reports_due.size() != 0 && guard < 4000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (reports_due.size() != 0)
            flag_mismatch("result words never delivered", reports_due.size(), 0);

        if (fault_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : watchdog
        #3000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
